>>> hdl/ria_pkg.sv
// shared types, constants and helpers for the radix integer to ascii unit
package ria_pkg;

  localparam int DEF_VALUE_WIDTH = 64;
  localparam int DEF_MAX_RADIX   = 36;

  localparam int MAG_W    = 64;
  localparam int RADIX_W  = 8;
  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 6;
  localparam int CHUNK_W  = 8;
  localparam int NCHUNK_W = 4;
  localparam int Q_DEPTH  = 2;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;
  localparam logic [CHAR_W-1:0]  ASCII_0   = 8'h30;
  localparam logic [CHAR_W-1:0]  ASCII_A   = 8'h61;
  localparam logic [CHAR_W-1:0]  ASCII_NUL = 8'h00;

  typedef struct packed {
    logic [MAG_W-1:0]   magnitude;
    logic [RADIX_W-1:0] radix;
    logic               negative;
  } cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              minus_first;
    logic              last;
    logic              error;
  } res_t;

  // one classified request waiting for the conversion engine
  typedef struct packed {
    logic [MAG_W-1:0]    value;
    logic [DIGIT_W-1:0]  radix;
    logic                negative;
    logic                error;
    logic [NCHUNK_W-1:0] chunks;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d >= DIGIT_TEN) begin
      return CHAR_W'(ext - {{(CHAR_W-DIGIT_W){1'b0}}, DIGIT_TEN} + ASCII_A);
    end
    return CHAR_W'(ext + ASCII_0);
  endfunction

endpackage

>>> hdl/radix_integer_to_ascii_unit.sv
// radix integer to ascii unit: request intake, queue and conversion engine
// each digit takes one division step per significant byte of the value left, then the
//   characters leave one per cycle
// a bad radix gives its single result, with the error flag, through the read stage and output register
// throughput: one request at a time in the engine, up to two more held in the queue
// results leave one per cycle and cannot be stalled; busy is high while the queue is full
// reset clears control state and the queue; the digit store is not cleared
module radix_integer_to_ascii_unit
  import ria_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int MAX_RADIX   = DEF_MAX_RADIX
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t command,
  output logic strobe,
  output res_t result
);

  entry_t    front_entry;
  entry_t    head;
  logic      push;
  logic      pop;
  q_status_t q_status;

  assign busy = q_status.full;

  ria_front #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_RADIX  (MAX_RADIX)
  ) u_front (
    .start   (start),
    .command (command),
    .q_status(q_status),
    .push    (push),
    .entry   (front_entry)
  );

  ria_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(front_entry),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  ria_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_status(q_status),
    .pop     (pop),
    .strobe  (strobe),
    .result  (result)
  );

endmodule

>>> hdl/ria_front.sv
// request intake: radix check, value masking and significant byte count
module ria_front
  import ria_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int MAX_RADIX   = DEF_MAX_RADIX
) (
  input  logic      start,
  input  cmd_t      command,
  input  q_status_t q_status,
  output logic      push,
  output entry_t    entry
);

  localparam int NCH = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam logic [MAG_W-1:0] VALUE_MASK = {MAG_W{1'b1}} >> (MAG_W - VALUE_WIDTH);

  logic [MAG_W-1:0]    masked;
  logic [NCHUNK_W-1:0] used_chunks;
  logic                radix_ok;

  assign masked   = command.magnitude & VALUE_MASK;
  assign radix_ok = command.radix inside {[RADIX_MIN : RADIX_W'(MAX_RADIX)]};
  assign push     = start & ~q_status.full;

  // number of bytes up to the highest nonzero one, at least one
  always_comb begin
    used_chunks = NCHUNK_W'(1);
    for (int i = 0; i < NCH; i++) begin
      if (|masked[i*CHUNK_W +: CHUNK_W]) begin
        used_chunks = NCHUNK_W'(i + 1);
      end
    end
  end

  always_comb begin
    entry.value    = masked;
    entry.radix    = command.radix[DIGIT_W-1:0];
    entry.negative = command.negative;
    entry.error    = ~radix_ok;
    entry.chunks   = used_chunks;
  end

endmodule

>>> hdl/ria_queue.sv
// two-entry request queue between intake and conversion engine
module ria_queue
  import ria_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  entry_t    push_entry,
  input  logic      pop,
  output entry_t    head,
  output q_status_t status
);

  localparam int PTR_W = $clog2(Q_DEPTH);

  entry_t                  slots [Q_DEPTH];
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        rd_ptr;
  logic [$clog2(Q_DEPTH+1)-1:0] count;

  assign head         = slots[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == ($clog2(Q_DEPTH+1))'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/ria_back.sv
// conversion engine: byte-wise long division by the radix, digit store, emission
module ria_back
  import ria_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  entry_t    head,
  input  q_status_t q_status,
  output logic      pop,
  output logic      strobe,
  output res_t      result
);

  localparam int NCH   = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W = NCH * CHUNK_W;
  localparam int IDX_W = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int CNT_W = $clog2(NCH + 1);
  localparam int AW    = $clog2(VALUE_WIDTH);
  localparam int DC_W  = $clog2(VALUE_WIDTH + 1);

  state_t state, state_next;

  logic [PAD_W-1:0]   val;
  logic [DIGIT_W-1:0] radix;
  logic               neg;
  logic [IDX_W-1:0]   chunk_idx;
  logic [CNT_W-1:0]   nch;
  logic [DIGIT_W-1:0] rem;
  logic               top_zero;
  logic [DC_W-1:0]    digit_count;
  logic [AW-1:0]      emit_idx;
  logic               first_pend;

  logic [DIGIT_W-1:0] digit_store [VALUE_WIDTH];

  // read stage
  logic               rd_valid;
  logic               rd_err;
  logic               rd_minus;
  logic               rd_last;
  logic [DIGIT_W-1:0] rd_data;

  // division datapath
  logic [CHUNK_W-1:0] chunk;
  logic [CHUNK_W-1:0] quo;
  logic [DIGIT_W-1:0] rem_out;
  logic               div_first;
  logic               top_zero_eff;
  logic [CNT_W-1:0]   nch_new;
  logic               digit_done;

  // control
  logic start_div;
  logic err_pop;
  logic store_we;
  logic emit_rd;

  assign chunk = val[{chunk_idx, 3'b000} +: CHUNK_W];

  // eight restoring steps, remainder stays below the radix
  always_comb begin
    logic [DIGIT_W:0] t;
    logic [DIGIT_W-1:0] r;
    r = rem;
    quo = '0;
    for (int b = CHUNK_W - 1; b >= 0; b--) begin
      t = {r, chunk[b]};
      if (t >= {1'b0, radix}) begin
        r = DIGIT_W'(t - {1'b0, radix});
        quo[b] = 1'b1;
      end else begin
        r = t[DIGIT_W-1:0];
        quo[b] = 1'b0;
      end
    end
    rem_out = r;
  end

  assign div_first    = (CNT_W'(chunk_idx) == CNT_W'(nch - 1'b1));
  assign top_zero_eff = div_first ? (quo == '0) : top_zero;
  assign nch_new      = top_zero_eff ? CNT_W'(nch - 1'b1) : nch;
  assign digit_done   = (chunk_idx == '0);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_status.empty && !head.error) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (digit_done && nch_new == '0) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_idx == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    start_div = 1'b0;
    err_pop   = 1'b0;
    store_we  = 1'b0;
    emit_rd   = 1'b0;
    case (state)
      ST_IDLE: begin
        pop       = ~q_status.empty;
        start_div = ~q_status.empty & ~head.error;
        err_pop   = ~q_status.empty & head.error;
      end
      ST_DIV:  store_we = digit_done;
      ST_EMIT: emit_rd = 1'b1;
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // digit store, least significant digit at address zero
  always_ff @(posedge clk) begin
    if (store_we) begin
      digit_store[digit_count[AW-1:0]] <= rem_out;
    end
    if (emit_rd) begin
      rd_data <= digit_store[emit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (start_div) begin
      val      <= head.value[PAD_W-1:0];
      radix    <= head.radix;
      neg      <= head.negative;
      rem      <= '0;
      top_zero <= 1'b0;
      chunk_idx <= IDX_W'(head.chunks[CNT_W-1:0] - 1'b1);
    end else if (state == ST_DIV) begin
      val[{chunk_idx, 3'b000} +: CHUNK_W] <= quo;
      if (digit_done) begin
        rem       <= '0;
        top_zero  <= 1'b0;
        chunk_idx <= IDX_W'(nch_new - 1'b1);
      end else begin
        rem       <= rem_out;
        top_zero  <= top_zero_eff;
        chunk_idx <= IDX_W'(chunk_idx - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nch         <= '0;
      digit_count <= '0;
      emit_idx    <= '0;
      first_pend  <= 1'b0;
      rd_valid    <= 1'b0;
      rd_err      <= 1'b0;
      rd_minus    <= 1'b0;
      rd_last     <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      if (start_div) begin
        nch         <= head.chunks[CNT_W-1:0];
        digit_count <= '0;
      end else if (store_we) begin
        nch         <= nch_new;
        digit_count <= DC_W'(digit_count + 1'b1);
        emit_idx    <= digit_count[AW-1:0];
        first_pend  <= 1'b1;
      end else if (emit_rd) begin
        emit_idx   <= AW'(emit_idx - 1'b1);
        first_pend <= 1'b0;
      end

      rd_valid <= emit_rd | err_pop;
      rd_err   <= err_pop;
      rd_minus <= emit_rd & first_pend & neg;
      rd_last  <= err_pop | (emit_rd & (emit_idx == '0));
      strobe   <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      result.character   <= rd_err ? ASCII_NUL : digit_to_ascii(rd_data);
      result.minus_first <= rd_minus;
      result.last        <= rd_last;
      result.error       <= rd_err;
    end
  end

  // a digit never reaches the radix
  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < radix))
    else $error("division remainder not below radix");

  // the working byte lies inside the significant part
  a_chunk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (nch != '0 && CNT_W'(chunk_idx) < nch))
    else $error("division byte index out of range");

  // the store never overflows
  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    store_we |-> (digit_count < DC_W'(VALUE_WIDTH)))
    else $error("digit store overflow");

  // an error request ends in exactly one result
  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (rd_valid && rd_err) |-> (rd_last && !rd_minus && $past(state) == ST_IDLE))
    else $error("malformed error result");

endmodule
